// ===== hdl/qrs_pkg.sv =====
// shared constants and types for the quadratic root solver
package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ROOT_W         = 41;
  localparam int CNT_W          = 2;

  localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             err;
  } qrs_ctl_t;

endpackage

// ===== hdl/qrs_if.sv =====
// valid/ready channel interfaces for coefficient items and root items
interface qrs_in_if #(parameter int COEF_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        root_count;
  logic signed [40:0] first_root;
  logic signed [40:0] second_root;
  logic              zero_lead_error;
  modport source (output valid, root_count, first_root, second_root, zero_lead_error,
                  input ready);
  modport sink   (input valid, root_count, first_root, second_root, zero_lead_error,
                  output ready);
endinterface

// ===== hdl/qrs_disc.sv =====
// two-stage front end: products, discriminant, root count, numerator and divisor
module qrs_disc import qrs_pkg::*; #(
  parameter int CW = COEF_WIDTH_DEF,
  parameter int F  = FRAC_BITS_DEF,
  localparam int XW  = 2*CW + 2 + 2*F,
  localparam int NBW = CW + 1 + F,
  localparam int DW  = CW + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  logic signed [CW-1:0]  a_i,
  input  logic signed [CW-1:0]  b_i,
  input  logic signed [CW-1:0]  c_i,
  output logic                  vld_o,
  output qrs_ctl_t              ctl_o,
  output logic [XW-1:0]         x_o,
  output logic signed [NBW-1:0] nb_o,
  output logic                  dsign_o,
  output logic [DW-1:0]         dmag_o
);
  localparam int DSW = 2*CW + 3;

  logic                   v1_r;
  logic signed [CW-1:0]   a1_r, b1_r;
  logic signed [2*CW-1:0] bb_r, ac_r;

  logic signed [DSW-1:0]  disc;
  logic signed [NBW-1:0]  b_x;
  logic [CW-1:0]          a_mag;
  qrs_ctl_t               ctl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      vld_o <= 1'b0;
    end else if (en) begin
      v1_r  <= vld_i;
      vld_o <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= a_i;
      b1_r <= b_i;
      bb_r <= b_i * b_i;
      ac_r <= a_i * c_i;
    end
  end

  always_comb begin
    disc = {{3{bb_r[2*CW-1]}}, bb_r} - ({{3{ac_r[2*CW-1]}}, ac_r} <<< 2);
    b_x  = {{(F+1){b1_r[CW-1]}}, b1_r};
    a_mag = a1_r[CW-1] ? (~a1_r + 1'b1) : a1_r;
    ctl_nxt.err = (a1_r == '0);
    if (ctl_nxt.err)            ctl_nxt.count = CNT_NONE;
    else if (!disc[DSW-1] && disc != '0) ctl_nxt.count = CNT_TWO;
    else if (disc == '0)        ctl_nxt.count = CNT_ONE;
    else                        ctl_nxt.count = CNT_NONE;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_o   <= ctl_nxt;
      // only a positive discriminant goes to the square root
      x_o     <= (ctl_nxt.count == CNT_TWO) ? (XW'(disc[2*CW:0]) << (2*F)) : '0;
      nb_o    <= (-b_x) <<< F;
      dsign_o <= a1_r[CW-1];
      dmag_o  <= {a_mag, 1'b0};
    end
  end
endmodule

// ===== hdl/qrs_sqrt.sv =====
// pipelined digit-by-digit square root, one root bit per stage, with sideband
module qrs_sqrt #(
  parameter int XW  = 66,
  parameter int SBW = 8,
  localparam int SW = XW / 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  logic [XW-1:0]  x_i,
  input  logic [SBW-1:0] sb_i,
  output logic           vld_o,
  output logic [SW-1:0]  root_o,
  output logic [SBW-1:0] sb_o
);
  localparam int RW = SW + 2;

  logic           vld_r  [SW];
  logic [RW-1:0]  rem_r  [SW];
  logic [SW-1:0]  root_r [SW];
  logic [XW-1:0]  x_r    [SW];
  logic [SBW-1:0] sb_r   [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic           vld_in;
    logic [RW-1:0]  rem_in;
    logic [SW-1:0]  root_in;
    logic [XW-1:0]  x_in;
    logic [SBW-1:0] sb_in;
    logic [RW+1:0]  rem_sh;
    logic [RW+1:0]  trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
      assign sb_in   = sb_i;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign x_in    = x_r[k-1];
      assign sb_in   = sb_r[k-1];
    end

    assign rem_sh = {rem_in, x_in[XW-1:XW-2]};
    assign trial  = (RW+2)'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k] <= 1'b0;
      else if (en) vld_r[k] <= vld_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? RW'(rem_sh - trial) : RW'(rem_sh);
        root_r[k] <= {root_in[SW-2:0], ge};
        x_r[k]    <= x_in << 2;
        sb_r[k]   <= sb_in;
      end
    end
  end

  assign vld_o  = vld_r[SW-1];
  assign root_o = root_r[SW-1];
  assign sb_o   = sb_r[SW-1];
endmodule

// ===== hdl/qrs_div.sv =====
// pipelined restoring divider on magnitudes, one quotient bit per stage
module qrs_div #(
  parameter int NW  = 34,
  parameter int DW  = 17,
  parameter int SBW = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  logic [NW-1:0]  n_i,
  input  logic [DW-1:0]  d_i,
  input  logic [SBW-1:0] sb_i,
  output logic           vld_o,
  output logic [NW-1:0]  q_o,
  output logic [SBW-1:0] sb_o
);
  logic           vld_r [NW];
  logic [DW-1:0]  r_r   [NW];
  logic [NW-1:0]  q_r   [NW];
  logic [NW-1:0]  n_r   [NW];
  logic [DW-1:0]  d_r   [NW];
  logic [SBW-1:0] sb_r  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic           vld_in;
    logic [DW-1:0]  r_in;
    logic [NW-1:0]  q_in;
    logic [NW-1:0]  n_in;
    logic [DW-1:0]  d_in;
    logic [SBW-1:0] sb_in;
    logic [DW:0]    r_sh;
    logic           ge;

    if (k == 0) begin : g_first
      assign vld_in = vld_i;
      assign r_in   = '0;
      assign q_in   = '0;
      assign n_in   = n_i;
      assign d_in   = d_i;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign r_in   = r_r[k-1];
      assign q_in   = q_r[k-1];
      assign n_in   = n_r[k-1];
      assign d_in   = d_r[k-1];
      assign sb_in  = sb_r[k-1];
    end

    assign r_sh = {r_in, n_in[NW-1]};
    assign ge   = (r_sh >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k] <= 1'b0;
      else if (en) vld_r[k] <= vld_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]  <= ge ? DW'(r_sh - {1'b0, d_in}) : DW'(r_sh);
        q_r[k]  <= {q_in[NW-2:0], ge};
        n_r[k]  <= n_in << 1;
        d_r[k]  <= d_in;
        sb_r[k] <= sb_in;
      end
    end
  end

  assign vld_o = vld_r[NW-1];
  assign q_o   = q_r[NW-1];
  assign sb_o  = sb_r[NW-1];
endmodule

// ===== hdl/quadratic_root_solver.sv =====
// top level of the quadratic root solver: front end, square root, two dividers
//
//   channel   dir   handshake          payload
//   in_chan   in    valid / ready      coef_a, coef_b, coef_c
//   out_chan  out   valid / ready      root_count, first_root, second_root, zero_lead_error
//
// one item per cycle while the output is not stalled; the pipeline holds one stage per bit
// of the square root and of each quotient.
// the whole pipeline advances while the output register is empty or being taken;
// a stall freezes every stage, so nothing is lost or repeated.
// reset is synchronous, active low, and clears only the valid bits.
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  qrs_in_if.sink      in_chan,
  qrs_out_if.source   out_chan
);
  localparam int CW    = COEF_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int XW    = 2*CW + 2 + 2*F;
  localparam int SW    = XW / 2;
  localparam int NBW   = CW + 1 + F;
  localparam int DW    = CW + 1;
  localparam int NW    = CW + 3 + F;
  localparam int QW    = NW - 1;
  localparam int CTLW  = $bits(qrs_ctl_t);
  localparam int SB1W  = CTLW + NBW + 1 + DW;
  localparam int SBPW  = CTLW + 1;
  localparam int SATW  = ((QW + 1 > ROOT_W) ? QW + 1 : ROOT_W) + 1;

  localparam logic signed [SATW-1:0] RMAX =
    {{(SATW-ROOT_W+1){1'b0}}, {(ROOT_W-1){1'b1}}};
  localparam logic signed [SATW-1:0] RMIN = ~RMAX;

  logic en;
  logic out_valid_r;

  // front end
  logic                  f_vld;
  qrs_ctl_t              f_ctl;
  logic [XW-1:0]         f_x;
  logic signed [NBW-1:0] f_nb;
  logic                  f_dsign;
  logic [DW-1:0]         f_dmag;

  // square root
  logic                  s_vld;
  logic [SW-1:0]         s_root;
  logic [SB1W-1:0]       s_sb;
  qrs_ctl_t              s_ctl;
  logic signed [NBW-1:0] s_nb;
  logic                  s_dsign;
  logic [DW-1:0]         s_dmag;

  // numerator stage
  logic signed [NW-1:0]  num_p, num_m;
  logic                  n_vld_r;
  logic [QW-1:0]         np_mag_r, nm_mag_r;
  logic [DW-1:0]         n_dmag_r;
  logic [SBPW-1:0]       n_sbp_r;
  logic                  n_negm_r;

  // dividers
  logic                  dp_vld, dm_vld;
  logic [QW-1:0]         qp, qm;
  logic [SBPW-1:0]       dp_sb;
  logic                  dm_sb;
  qrs_ctl_t              d_ctl;
  logic                  d_negp;
  logic [ROOT_W-1:0]     rp_sat, rm_sat;

  function automatic logic [ROOT_W-1:0] sat_root(input logic [QW-1:0] mag, input logic neg);
    logic signed [QW:0]     qs;
    logic signed [SATW-1:0] v;
    qs = {1'b0, mag};
    qs = neg ? -qs : qs;
    v  = {{(SATW-QW-1){qs[QW]}}, qs};
    if (v > RMAX)      v = RMAX;
    else if (v < RMIN) v = RMIN;
    return v[ROOT_W-1:0];
  endfunction

  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  qrs_disc #(.CW(CW), .F(F)) u_disc (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (in_chan.valid),
    .a_i     (in_chan.coef_a),
    .b_i     (in_chan.coef_b),
    .c_i     (in_chan.coef_c),
    .vld_o   (f_vld),
    .ctl_o   (f_ctl),
    .x_o     (f_x),
    .nb_o    (f_nb),
    .dsign_o (f_dsign),
    .dmag_o  (f_dmag)
  );

  qrs_sqrt #(.XW(XW), .SBW(SB1W)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (f_vld),
    .x_i    (f_x),
    .sb_i   ({f_ctl, f_nb, f_dsign, f_dmag}),
    .vld_o  (s_vld),
    .root_o (s_root),
    .sb_o   (s_sb)
  );

  assign {s_ctl, s_nb, s_dsign, s_dmag} = s_sb;

  always_comb begin
    num_p = {{2{s_nb[NBW-1]}}, s_nb} + {2'b00, s_root};
    num_m = {{2{s_nb[NBW-1]}}, s_nb} - {2'b00, s_root};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) n_vld_r <= 1'b0;
    else if (en) n_vld_r <= s_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      np_mag_r <= num_p[NW-1] ? QW'(-num_p) : num_p[QW-1:0];
      nm_mag_r <= num_m[NW-1] ? QW'(-num_m) : num_m[QW-1:0];
      n_dmag_r <= s_dmag;
      // quotient sign follows the signs of numerator and divisor
      n_sbp_r  <= {s_ctl, num_p[NW-1] ^ s_dsign};
      n_negm_r <= num_m[NW-1] ^ s_dsign;
    end
  end

  qrs_div #(.NW(QW), .DW(DW), .SBW(SBPW)) u_div_p (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (n_vld_r),
    .n_i   (np_mag_r),
    .d_i   (n_dmag_r),
    .sb_i  (n_sbp_r),
    .vld_o (dp_vld),
    .q_o   (qp),
    .sb_o  (dp_sb)
  );

  qrs_div #(.NW(QW), .DW(DW), .SBW(1)) u_div_m (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (n_vld_r),
    .n_i   (nm_mag_r),
    .d_i   (n_dmag_r),
    .sb_i  (n_negm_r),
    .vld_o (dm_vld),
    .q_o   (qm),
    .sb_o  (dm_sb)
  );

  assign {d_ctl, d_negp} = dp_sb;
  assign rp_sat = sat_root(qp, d_negp);
  assign rm_sat = sat_root(qm, dm_sb);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= dp_vld && dm_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_chan.root_count      <= d_ctl.count;
      out_chan.zero_lead_error <= d_ctl.err;
      out_chan.first_root      <= (d_ctl.count != CNT_NONE) ? rp_sat : '0;
      out_chan.second_root     <= (d_ctl.count == CNT_TWO) ? rm_sat : '0;
    end
  end

  assign out_chan.valid = out_valid_r;
endmodule

// ===== hdl/qrs_checker.sv =====
// port-level checks on the quadratic root solver, bound to the top level
module qrs_checker import qrs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        root_count,
  input logic signed [40:0] first_root,
  input logic signed [40:0] second_root,
  input logic              zero_lead_error
);
  a_err_no_roots: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_lead_error |-> root_count == CNT_NONE)
    else $error("error item carries roots");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && root_count == CNT_NONE |-> first_root == '0 && second_root == '0)
    else $error("root slots not cleared");

  a_second_unused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && root_count != CNT_TWO |-> second_root == '0)
    else $error("second root slot not cleared");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> root_count == CNT_NONE || root_count == CNT_ONE || root_count == CNT_TWO)
    else $error("bad root count");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(first_root) && $stable(second_root))
    else $error("stalled item changed");
endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .root_count      (out_chan.root_count),
  .first_root      (out_chan.first_root),
  .second_root     (out_chan.second_root),
  .zero_lead_error (out_chan.zero_lead_error)
);
